@@ rtl/acpg_pkg.sv @@
// Package: shared types, constants and AES helper functions for the counter PRF.
package acpg_pkg;

   localparam int MaxBlocksDefault = 16;
   localparam int LenWidth         = 12;
   localparam int BlockShift       = 7;

   typedef struct packed {
      logic [63:0] counter_value;
      logic [11:0] length_bits;
   } req_type;

   typedef struct packed {
      logic [63:0] data_low;
      logic [63:0] data_high;
      logic        last_block;
   } rsp_type;

   typedef enum logic [0:0] {
      CSR_KEY_LOW  = 1'b0,
      CSR_KEY_HIGH = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEED,
      ST_BLOCK,
      ST_WAIT,
      ST_SEND,
      ST_HOLD
   } ctrl_state_type;

   typedef enum logic [1:0] {
      PH_LOAD,
      PH_ROUND,
      PH_DONE
   } core_phase_type;

   // control bundle from the controller to the cipher core
   typedef struct packed {
      logic         start;
      logic [127:0] block;
   } core_cmd_type;

   typedef struct packed {
      logic         done;
      logic [127:0] block;
   } core_sts_type;

   function automatic logic [7:0] sbox(input logic [7:0] a);
      logic [7:0] t [256];
      t = '{
  8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
  8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
  8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
  8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
  8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
  8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
  8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
  8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
  8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
  8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
  8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
  8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
  8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
  8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
  8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
  8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return t[a];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

endpackage

@@ rtl/acpg_core.sv @@
// Cipher core: AES-128 encryption, one byte of SubBytes per cycle, round key on the fly.
module acpg_core
   import acpg_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic [127:0] key,
   input  core_cmd_type cmd,
   output core_sts_type sts
);

   core_phase_type phase_ff, phase_in;
   logic [127:0]   state_ff, state_in;
   logic [127:0]   rkey_ff, rkey_in;
   logic [7:0]     rcon_ff, rcon_in;
   logic [3:0]     round_ff, round_in;
   logic [4:0]     step_ff, step_in;
   logic [127:0]   sub;
   logic [127:0]   mixed;
   logic [127:0]   nkey;
   logic [31:0]    tw;

   // next round key, one word of S-box per round
   always_comb begin
      tw   = {sbox(rkey_ff[103:96]), sbox(rkey_ff[127:120]),
              sbox(rkey_ff[119:112]), sbox(rkey_ff[111:104])};
      tw[7:0] = tw[7:0] ^ rcon_ff;
      nkey[31:0]   = rkey_ff[31:0] ^ tw;
      nkey[63:32]  = rkey_ff[63:32] ^ nkey[31:0];
      nkey[95:64]  = rkey_ff[95:64] ^ nkey[63:32];
      nkey[127:96] = rkey_ff[127:96] ^ nkey[95:64];
   end

   // shift rows and mix columns over the substituted state
   always_comb begin
      logic [7:0] a0, a1, a2, a3, al;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            sub[8*(r+4*c) +: 8] = state_ff[8*(r+4*((c+r)%4)) +: 8];
         end
      end
      for (int c = 0; c < 4; c++) begin
         a0 = sub[32*c +: 8];
         a1 = sub[32*c+8 +: 8];
         a2 = sub[32*c+16 +: 8];
         a3 = sub[32*c+24 +: 8];
         al = a0 ^ a1 ^ a2 ^ a3;
         mixed[32*c +: 8]    = a0 ^ al ^ xtime(a0 ^ a1);
         mixed[32*c+8 +: 8]  = a1 ^ al ^ xtime(a1 ^ a2);
         mixed[32*c+16 +: 8] = a2 ^ al ^ xtime(a2 ^ a3);
         mixed[32*c+24 +: 8] = a3 ^ al ^ xtime(a3 ^ a0);
      end
   end

   // sequence: load, then per round 16 byte substitutions through a rotating shift and one combine step, then done
   always_comb begin
      phase_in = phase_ff;
      state_in = state_ff;
      rkey_in  = rkey_ff;
      rcon_in  = rcon_ff;
      round_in = round_ff;
      step_in  = step_ff;
      sts.done  = 1'b0;
      sts.block = state_ff;
      unique case (phase_ff)
         PH_LOAD: begin
            if (cmd.start) begin
               state_in = cmd.block ^ key;
               rkey_in  = key;
               rcon_in  = 8'h01;
               round_in = 4'd1;
               step_in  = '0;
               phase_in = PH_ROUND;
            end
         end
         PH_ROUND: begin
            if (step_ff != 5'd16) begin
               // substitute byte 0 and rotate the state by one byte
               state_in = {sbox(state_ff[7:0]), state_ff[127:8]};
               step_in  = step_ff + 5'd1;
            end else begin
               state_in = ((round_ff == 4'd10) ? sub : mixed) ^ nkey;
               rkey_in  = nkey;
               rcon_in  = xtime(rcon_ff);
               step_in  = '0;
               round_in = round_ff + 4'd1;
               if (round_ff == 4'd10) begin
                  phase_in = PH_DONE;
               end
            end
         end
         PH_DONE: begin
            sts.done = 1'b1;
            phase_in = PH_LOAD;
         end
         default: phase_in = PH_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LOAD;
      end else begin
         phase_ff <= phase_in;
      end
      state_ff <= state_in;
      rkey_ff  <= rkey_in;
      rcon_ff  <= rcon_in;
      round_ff <= round_in;
      step_ff  <= step_in;
   end

endmodule

@@ rtl/aes_counter_prf_generator.sv @@
// Top level: AES-128 counter PRF, request control, key registers and output register.
// Each AES encryption runs load, 10 rounds of 16 byte-serial S-box steps plus one combine
// step, then done, as set by the single byte-wide substitution path in the core.
// A request of n blocks runs a seed and n block encryptions before the next one is taken,
// longer while a result still waits as a block finishes; a zero-length request is dropped.
// Synchronous active-high reset clears the key to zero and returns control to idle.
module aes_counter_prf_generator
   import acpg_pkg::*;
#(
   parameter int MAX_BLOCKS = MaxBlocksDefault
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [63:0] csr_data
);

   localparam int CntWidth = $clog2(MAX_BLOCKS + 1);

   ctrl_state_type state_ff, state_in;
   logic [63:0]    key_low_ff, key_high_ff;
   logic [127:0]   work_ff, work_in;
   logic [CntWidth-1:0] nblk_ff, nblk_in;
   logic [CntWidth-1:0] idx_ff, idx_in;
   rsp_type        rsp_ff, rsp_in;
   logic           rsp_valid_ff, rsp_valid_in;
   core_cmd_type   cmd;
   core_sts_type   sts;
   logic [LenWidth-BlockShift:0] raw_blocks;
   logic [7:0]     idx_byte;

   acpg_core u_core (
      .clock (clock),
      .reset (reset),
      .key   ({key_high_ff, key_low_ff}),
      .cmd   (cmd),
      .sts   (sts)
   );

   // write key registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_KEY_LOW:  key_low_ff  <= csr_data;
            CSR_KEY_HIGH: key_high_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign raw_blocks = (LenWidth-BlockShift+1)'(
                          ({1'b0, req_data.length_bits} + (LenWidth+1)'(127)) >> BlockShift);
   assign idx_byte   = 8'(idx_ff);
   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // request control
   always_comb begin
      state_in     = state_ff;
      work_in      = work_ff;
      nblk_in      = nblk_ff;
      idx_in       = idx_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd.start    = 1'b0;
      cmd.block    = work_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               work_in = {64'd0, req_data.counter_value};
               idx_in  = '0;
               if (8'(raw_blocks) > 8'(MAX_BLOCKS)) begin
                  nblk_in = CntWidth'(MAX_BLOCKS);
               end else begin
                  nblk_in = CntWidth'(raw_blocks);
               end
               if (raw_blocks != '0) begin
                  state_in = ST_SEED;
               end
            end
         end
         ST_SEED: begin
            cmd.start = 1'b1;
            state_in  = ST_WAIT;
         end
         ST_WAIT: begin
            if (sts.done) begin
               state_in = ST_BLOCK;
            end
         end
         ST_BLOCK: begin
            cmd.start = 1'b1;
            state_in  = ST_SEND;
         end
         ST_SEND, ST_HOLD: begin
            // hold a finished block in the core while the output register is occupied
            if (sts.done || state_ff == ST_HOLD) begin
               if (rsp_valid_in) begin
                  state_in = ST_HOLD;
               end else begin
                  rsp_in.data_low   = sts.block[63:0];
                  rsp_in.data_high  = sts.block[127:64];
                  rsp_in.last_block = (idx_ff + CntWidth'(1) == nblk_ff);
                  rsp_valid_in      = 1'b1;
                  idx_in            = idx_ff + CntWidth'(1);
                  if (idx_ff + CntWidth'(1) == nblk_ff) begin
                     state_in = ST_IDLE;
                  end else begin
                     state_in = ST_BLOCK;
                     work_in  = {work_ff[127:8], work_ff[7:0] ^ 8'(idx_ff + CntWidth'(1))};
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // seed result lands here and takes the first cumulative XOR by zero
      if (state_ff == ST_WAIT && sts.done) begin
         work_in = {sts.block[127:8], sts.block[7:0] ^ idx_byte};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      work_ff <= work_in;
      nblk_ff <= nblk_in;
      idx_ff  <= idx_in;
      rsp_ff  <= rsp_in;
   end

endmodule
